/* rtl/aes128_pkg.sv */
`default_nettype none
package aes128_pkg;

    localparam int NumRounds = 10;

    typedef logic [127:0] block_t;

    // stage payload handed from one round cell to the next
    typedef struct packed {
        block_t state;
        block_t round_key;
    } stage_t;

    function automatic logic [7:0] sbox(input logic [7:0] x);
        logic [7:0] r;
        begin
            case (x)
                8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
                8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
                8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
                8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
                8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
                8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
                8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
                8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
                8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
                8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
                8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
                8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
                8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
                8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
                8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
                8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
                8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
                8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
                8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
                8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
                8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
                8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
                8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
                8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
                8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
                8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
                8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
                8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
                8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
                8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
                8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
                8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
                8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
                8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
                8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
                8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
                8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
                8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
                8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
                8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
                8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
                8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
                8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
                8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
                8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
                8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
                8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
                8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
                8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
                8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
                8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
                8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
                8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
                8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
                8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
                8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
                8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
                8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
                8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
                8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
                8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
                8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
                8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
                8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] idx);
        logic [7:0] r;
        begin
            case (idx)
                4'd1: r = 8'h01; 4'd2: r = 8'h02; 4'd3: r = 8'h04; 4'd4: r = 8'h08;
                4'd5: r = 8'h10; 4'd6: r = 8'h20; 4'd7: r = 8'h40; 4'd8: r = 8'h80;
                4'd9: r = 8'h1b; 4'd10: r = 8'h36;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/aes128_stream_if.sv */
`default_nettype none
interface aes128_stream_if;
    logic        valid;
    logic        ready;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [63:0] key_high;
    logic [63:0] key_low;

    modport source (output valid, data_high, data_low, key_high, key_low, input ready);
    modport sink (input valid, data_high, data_low, key_high, key_low, output ready);
endinterface
`default_nettype wire

/* rtl/aes128_result_if.sv */
`default_nettype none
interface aes128_result_if;
    logic        valid;
    logic        ready;
    logic [63:0] ciphertext_high;
    logic [63:0] ciphertext_low;

    modport source (output valid, ciphertext_high, ciphertext_low, input ready);
    modport sink (input valid, ciphertext_high, ciphertext_low, output ready);
endinterface
`default_nettype wire

/* rtl/aes128_round_cell.sv */
`default_nettype none
// one round: sub bytes, shift rows, optional mix columns, add round key,
// plus the matching key expansion step; registered output
module aes128_round_cell (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   advance,
    input  wire logic [3:0]             round_idx,
    input  wire logic                   skip_mix,
    input  wire logic                   valid_in,
    input  wire aes128_pkg::stage_t     stage_in,
    output      logic                   valid_out,
    output      aes128_pkg::stage_t     stage_out
);

    logic [7:0]          s_in [16];
    logic [7:0]          sh [16];
    logic [7:0]          mx [16];
    logic [127:0]        mixed;
    logic [31:0]         w [4];
    logic [31:0]         nw [4];
    logic [31:0]         rot;
    logic                valid_reg;
    aes128_pkg::stage_t  stage_reg;
    aes128_pkg::stage_t  stage_next;

    // byte view, sub bytes with shift rows
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            s_in[i] = stage_in.state[127 - 8*i -: 8];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sh[r + 4*c] = aes128_pkg::sbox(s_in[r + 4*((c + r) % 4)]);
            end
        end
    end

    // mix columns
    always_comb
    begin
        logic [7:0] all;
        for (int c = 0; c < 4; c++)
        begin
            all = sh[4*c] ^ sh[4*c+1] ^ sh[4*c+2] ^ sh[4*c+3];
            for (int r = 0; r < 4; r++)
            begin
                mx[4*c + r] = sh[4*c + r] ^ all
                    ^ aes128_pkg::xtime(sh[4*c + r] ^ sh[4*c + ((r + 1) % 4)]);
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            mixed[127 - 8*i -: 8] = skip_mix ? sh[i] : mx[i];
        end
    end

    // key expansion step
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            w[i] = stage_in.round_key[127 - 32*i -: 32];
        end
        rot = {aes128_pkg::sbox(w[3][23:16]) ^ aes128_pkg::rcon(round_idx),
               aes128_pkg::sbox(w[3][15:8]), aes128_pkg::sbox(w[3][7:0]),
               aes128_pkg::sbox(w[3][31:24])};
        nw[0] = w[0] ^ rot;
        nw[1] = w[1] ^ nw[0];
        nw[2] = w[2] ^ nw[1];
        nw[3] = w[3] ^ nw[2];
        stage_next.round_key = {nw[0], nw[1], nw[2], nw[3]};
        stage_next.state = mixed ^ stage_next.round_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg <= stage_next;
        end
    end

    assign valid_out = valid_reg;
    assign stage_out = stage_reg;

endmodule
`default_nettype wire

/* rtl/aes128_block_encrypt.sv */
// the initial key add register loads at the input transfer edge, then each of
// the ten round cells registers the state in turn
// throughput: one block per cycle unless the output stalls, set by the ten-cell round chain
// the whole chain stalls only when the result is held and not taken
// reset clears all valid bits; payload registers are not reset
`default_nettype none
module aes128_block_encrypt (
    input  wire logic      clk,
    input  wire logic      rst_n,
    aes128_stream_if.sink  in_chan,
    aes128_result_if.source out_chan
);

    logic                valid_chain [aes128_pkg::NumRounds + 1];
    aes128_pkg::stage_t  stage_chain [aes128_pkg::NumRounds + 1];
    logic                advance;
    logic                valid0_reg;
    aes128_pkg::stage_t  stage0_reg;

    // chain moves when the final stage is empty or being taken
    assign advance       = !valid_chain[aes128_pkg::NumRounds] || out_chan.ready;
    assign in_chan.ready = advance;

    // initial add round key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid0_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid0_reg <= in_chan.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage0_reg.round_key <= {in_chan.key_high, in_chan.key_low};
            stage0_reg.state <= {in_chan.data_high, in_chan.data_low}
                ^ {in_chan.key_high, in_chan.key_low};
        end
    end

    assign valid_chain[0] = valid0_reg;
    assign stage_chain[0] = stage0_reg;

    // round cells
    for (genvar g = 0; g < aes128_pkg::NumRounds; g++)
    begin : g_round
        aes128_round_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .advance    (advance),
            .round_idx  (4'(g + 1)),
            .skip_mix   (g == aes128_pkg::NumRounds - 1),
            .valid_in   (valid_chain[g]),
            .stage_in   (stage_chain[g]),
            .valid_out  (valid_chain[g + 1]),
            .stage_out  (stage_chain[g + 1])
        );
    end

    assign out_chan.valid           = valid_chain[aes128_pkg::NumRounds];
    assign out_chan.ciphertext_high = stage_chain[aes128_pkg::NumRounds].state[127:64];
    assign out_chan.ciphertext_low  = stage_chain[aes128_pkg::NumRounds].state[63:0];

endmodule
`default_nettype wire

/* rtl/aes128_checker.sv */
`default_nettype none
module aes128_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [63:0] ct_high,
    input wire logic [63:0] ct_low
);

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ct_high) && $stable(ct_low))
        else $error("stalled result changed");

    // input is taken whenever the result side is free
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // input stalls only while the output is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // no result appears out of an empty pipe
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !out_valid)
        else $error("result right after reset");

endmodule

bind aes128_block_encrypt aes128_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .ct_high   (out_chan.ciphertext_high),
    .ct_low    (out_chan.ciphertext_low)
);
`default_nettype wire

/* verif/aes128_block_encrypt_test.sv */
`timescale 1ns / 1ps
`default_nettype none
module aes128_block_encrypt_test;

    localparam int RandomBlocks = 830;
    localparam int Latency = 11;

    typedef struct {
        logic [63:0] pt_high;
        logic [63:0] pt_low;
        logic [63:0] key_high;
        logic [63:0] key_low;
        logic        known;
        logic [63:0] ct_high;
        logic [63:0] ct_low;
    } vector_t;

    typedef struct {
        logic [63:0] high;
        logic [63:0] low;
    } cipher_t;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   blocks_sent;
    int   blocks_checked;
    bit   sink_stall_mode;

    cipher_t ciphertext_queue[$];
    vector_t directed[$];

    aes128_stream_if in_chan ();
    aes128_result_if out_chan ();

    aes128_block_encrypt dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan.sink),
        .out_chan(out_chan.source)
    );

    // forward s-box, built by inverse and affine map
    logic [7:0] sub_bytes_lut[256];

    function automatic logic [7:0] gf_mul(logic [7:0] a, logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    function automatic logic [7:0] rotl8(logic [7:0] x, int n);
        return (x << n) | (x >> (8 - n));
    endfunction

    initial
    begin
        logic [7:0] inv;
        for (int x = 0; x < 256; x++)
        begin
            inv = 8'h00;
            for (int y = 1; y < 256; y++)
                if (gf_mul(x[7:0], y[7:0]) == 8'h01)
                    inv = y[7:0];
            sub_bytes_lut[x] = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3)
                ^ rotl8(inv, 4) ^ 8'h63;
        end
    end

    function automatic logic [7:0] dbl(logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // full aes-128 encryption of one block, bytes in fips order
    function automatic cipher_t encrypt_block(logic [63:0] ph, logic [63:0] pl,
                                              logic [63:0] kh, logic [63:0] kl);
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] w[44][4];
        logic [7:0] t[4];
        logic [7:0] rc;
        logic [7:0] a0, a1, a2, a3, all;
        logic [127:0] blk;
        logic [127:0] key;
        cipher_t res;
        blk = {ph, pl};
        key = {kh, kl};
        for (int i = 0; i < 16; i++)
        begin
            st[i] = blk[127 - 8 * i -: 8];
            w[i / 4][i % 4] = key[127 - 8 * i -: 8];
        end
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            for (int j = 0; j < 4; j++)
                t[j] = w[i - 1][j];
            if (i % 4 == 0)
            begin
                t = '{sub_bytes_lut[w[i - 1][1]] ^ rc, sub_bytes_lut[w[i - 1][2]],
                      sub_bytes_lut[w[i - 1][3]], sub_bytes_lut[w[i - 1][0]]};
                rc = dbl(rc);
            end
            for (int j = 0; j < 4; j++)
                w[i][j] = w[i - 4][j] ^ t[j];
        end
        for (int i = 0; i < 16; i++)
            st[i] ^= w[i / 4][i % 4];
        for (int rnd = 1; rnd <= 10; rnd++)
        begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[r + 4 * c] = sub_bytes_lut[st[r + 4 * ((c + r) % 4)]];
            st = tmp;
            if (rnd < 10)
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[4 * c];
                    a1 = st[4 * c + 1];
                    a2 = st[4 * c + 2];
                    a3 = st[4 * c + 3];
                    all = a0 ^ a1 ^ a2 ^ a3;
                    st[4 * c]     = a0 ^ all ^ dbl(a0 ^ a1);
                    st[4 * c + 1] = a1 ^ all ^ dbl(a1 ^ a2);
                    st[4 * c + 2] = a2 ^ all ^ dbl(a2 ^ a3);
                    st[4 * c + 3] = a3 ^ all ^ dbl(a3 ^ a0);
                end
            for (int i = 0; i < 16; i++)
                st[i] ^= w[4 * rnd + i / 4][i % 4];
        end
        for (int i = 0; i < 16; i++)
            blk[127 - 8 * i -: 8] = st[i];
        res.high = blk[127:64];
        res.low = blk[63:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        mismatches++;
    endtask

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // reset
    initial
    begin
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // timeout
    initial
    begin
        #2000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

    // directed table: known answers first, then edge patterns
    function automatic vector_t row(logic [63:0] ph, logic [63:0] pl, logic [63:0] kh,
                                    logic [63:0] kl, logic known = 1'b0,
                                    logic [63:0] ch = '0, logic [63:0] cl = '0);
        vector_t v;
        v = '{ph, pl, kh, kl, known, ch, cl};
        return v;
    endfunction

    // sparse key patterns: mostly zeros or ones with one random byte
    function automatic logic [63:0] kh_mask();
        logic [63:0] base;
        base = $urandom_range(0, 1) ? '1 : '0;
        base[8 * $urandom_range(0, 7) +: 8] = 8'($urandom);
        return base;
    endfunction

    initial
    begin
        directed.push_back(row(64'h3243f6a8885a308d, 64'h313198a2e0370734,
            64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1,
            64'h3925841d02dc09fb, 64'hdc118597196a0b32));
        directed.push_back(row(64'h0011223344556677, 64'h8899aabbccddeeff,
            64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1,
            64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a));
        directed.push_back(row('0, '0, '0, '0, 1'b1,
            64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e));
        directed.push_back(row('1, '1, '1, '1));
        directed.push_back(row('0, '0, '1, '1));
        directed.push_back(row('1, '1, '0, '0));
        directed.push_back(row(64'h8000000000000000, '0, '0, '0));
        directed.push_back(row('0, 64'h1, '0, '0));
        directed.push_back(row('0, '0, 64'h8000000000000000, '0));
        directed.push_back(row('0, '0, '0, 64'h1));
        directed.push_back(row({8{8'haa}}, {8{8'h55}}, {8{8'h55}}, {8{8'haa}}));
        directed.push_back(row({8{8'h55}}, {8{8'haa}}, {8{8'haa}}, {8{8'h55}}));
        directed.push_back(row(64'h0123456789abcdef, 64'hfedcba9876543210,
            64'hffffffffffffffff, 64'h0));
    end

    // sender: bursts with gaps, one full drain in the middle
    initial
    begin
        vector_t v;
        cipher_t c;
        int burst;
        int total;
        in_chan.valid <= 1'b0;
        in_chan.data_high <= '0;
        in_chan.data_low <= '0;
        in_chan.key_high <= '0;
        in_chan.key_low <= '0;
        mismatches = 0;
        blocks_sent = 0;
        blocks_checked = 0;
        @(posedge clk);
        wait (rst_n === 1'b1);
        total = directed.size() + RandomBlocks;
        burst = $urandom_range(1, 20);
        while (blocks_sent < total)
        begin
            if (blocks_sent < directed.size())
                v = directed[blocks_sent];
            else if ($urandom_range(0, 3) == 0)
                v = row({$urandom, $urandom}, {$urandom, $urandom}, kh_mask(), kh_mask());
            else
                v = row({$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
            c = encrypt_block(v.pt_high, v.pt_low, v.key_high, v.key_low);
            if (v.known && (c.high !== v.ct_high || c.low !== v.ct_low))
                $display("predictor disagrees with known answer %0d", blocks_sent);
            in_chan.valid <= 1'b1;
            in_chan.data_high <= v.pt_high;
            in_chan.data_low <= v.pt_low;
            in_chan.key_high <= v.key_high;
            in_chan.key_low <= v.key_low;
            @(posedge clk);
            while (in_chan.ready !== 1'b1)
                @(posedge clk);
            if (v.known)
            begin
                c.high = v.ct_high;
                c.low = v.ct_low;
            end
            ciphertext_queue.push_back(c);
            blocks_sent++;
            burst--;
            if (blocks_sent == total / 2)
            begin
                in_chan.valid <= 1'b0;
                while (ciphertext_queue.size() != 0)
                    @(posedge clk);
            end
            else if (burst == 0)
            begin
                burst = $urandom_range(1, 30);
                if ($urandom_range(0, 2) != 0)
                begin
                    in_chan.valid <= 1'b0;
                    repeat ($urandom_range(1, 12)) @(posedge clk);
                end
            end
        end
        in_chan.valid <= 1'b0;
        while (ciphertext_queue.size() != 0)
            @(posedge clk);
        repeat (Latency + 5) @(posedge clk);
        $display("encrypted %0d blocks (%0d with fixed answers), %0d results checked",
                 blocks_sent, 3, blocks_checked);
        $display("covered all-zero/all-one fields, single-bit and random keys, stalls");
        if (mismatches == 0 && ciphertext_queue.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // receiver: stall pattern alternates between phases
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_chan.ready <= 1'b0;
            sink_stall_mode <= 1'b0;
        end
        else
        begin
            if ($urandom_range(0, 63) == 0)
                sink_stall_mode <= ~sink_stall_mode;
            if (sink_stall_mode)
                out_chan.ready <= ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1;
            else
                out_chan.ready <= ($urandom_range(0, 9) != 0);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        cipher_t want;
        if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1)
        begin
            if (ciphertext_queue.size() == 0)
            begin
                $display("unexpected result %h %h", out_chan.ciphertext_high,
                         out_chan.ciphertext_low);
                mismatches++;
            end
            else
            begin
                want = ciphertext_queue.pop_front();
                blocks_checked++;
                if (out_chan.ciphertext_high !== want.high)
                    report_mismatch("ciphertext_high", out_chan.ciphertext_high, want.high);
                if (out_chan.ciphertext_low !== want.low)
                    report_mismatch("ciphertext_low", out_chan.ciphertext_low, want.low);
            end
        end
    end

endmodule
`default_nettype wire

/* sim.f */
rtl/aes128_pkg.sv
rtl/aes128_stream_if.sv
rtl/aes128_result_if.sv
rtl/aes128_round_cell.sv
rtl/aes128_block_encrypt.sv
rtl/aes128_checker.sv
verif/aes128_block_encrypt_test.sv
